// ----- rtl/fsmo_pkg.sv -----
// Shared types and codes for the frame slot manager.
package fsmo_pkg;

  localparam int unsigned SEQ_W      = 64;
  localparam int unsigned DROP_W     = 32;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned NSLOT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;
  // index width of the widest build (64 slots)
  localparam int unsigned IDX_MAX_W  = 6;

  localparam logic [ACTION_W-1:0] ACT_PUBLISH = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ACQUIRE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FATAL   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_CAPACITY = 4'd1;

  localparam logic [NSLOT_W-1:0]    RST_SLOTS_IN_USE  = 5'd16;
  localparam logic [CFG_DATA_W-1:0] RST_SLOT_CAPACITY = 16'd4096;

  // one slot presented to the scan unit
  typedef struct packed {
    logic                 clear;
    logic                 elem_vld;
    logic [IDX_MAX_W-1:0] elem_idx;
    logic                 elem_free;
    logic                 elem_readable;
  } scan_ctrl_t;

  // running scan outcome
  typedef struct packed {
    logic                 free_found;
    logic [IDX_MAX_W-1:0] free_idx;
    logic                 best_found;
    logic [IDX_MAX_W-1:0] best_idx;
    logic [SEQ_W-1:0]     oldest_seq;
  } scan_res_t;

endpackage

// ----- rtl/fsmo_if.sv -----
// Handshake interfaces for request, result and configuration channels.
interface fsmo_in_if;
  logic                             valid;
  logic                             ready;
  logic [fsmo_pkg::ACTION_W-1:0]    action;
  logic [fsmo_pkg::SIZE_W-1:0]      frame_size;
  logic [fsmo_pkg::SLOT_W-1:0]      release_index;
  modport source (output valid, action, frame_size, release_index, input ready);
  modport sink   (input valid, action, frame_size, release_index, output ready);
endinterface

interface fsmo_out_if;
  logic                             valid;
  logic                             ready;
  logic [fsmo_pkg::STATUS_W-1:0]    status;
  logic [fsmo_pkg::SLOT_W-1:0]      slot_number;
  logic [fsmo_pkg::SEQ_W-1:0]       frame_sequence;
  logic                             overwrote_old;
  logic [fsmo_pkg::DROP_W-1:0]      drop_count;
  modport source (output valid, status, slot_number, frame_sequence, overwrote_old,
                  drop_count, input ready);
  modport sink   (input valid, status, slot_number, frame_sequence, overwrote_old,
                  drop_count, output ready);
endinterface

interface fsmo_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fsmo_pkg::CFG_IDX_W-1:0]    index;
  logic [fsmo_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/fsmo_seq_ram.sv -----
// Sequence number store: one write port, one registered read port.
module fsmo_seq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [fsmo_pkg::SEQ_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [fsmo_pkg::SEQ_W-1:0] rdata_o
);

  logic [fsmo_pkg::SEQ_W-1:0] mem_q [DEPTH];
  logic [fsmo_pkg::SEQ_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fsmo_scan.sv -----
// Shared scan unit: first free slot and oldest readable slot, one slot a cycle.
module fsmo_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fsmo_pkg::scan_ctrl_t       ctrl_i,
  input  logic [fsmo_pkg::SEQ_W-1:0] seq_i,
  output fsmo_pkg::scan_res_t        res_o
);

  fsmo_pkg::scan_res_t res_q, res_d;

  always_comb begin
    res_d = res_q;
    if (ctrl_i.clear) begin
      res_d.free_found = 1'b0;
      res_d.best_found = 1'b0;
    end else if (ctrl_i.elem_vld) begin
      if (ctrl_i.elem_free && !res_q.free_found) begin
        res_d.free_found = 1'b1;
        res_d.free_idx   = ctrl_i.elem_idx;
      end
      // the one 64-bit comparator of the block
      if (ctrl_i.elem_readable && (!res_q.best_found || (seq_i < res_q.oldest_seq))) begin
        res_d.best_found = 1'b1;
        res_d.best_idx   = ctrl_i.elem_idx;
        res_d.oldest_seq = seq_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- rtl/frame_slot_manager_overwrite_oldest_core.sv -----
// Frame slot manager top level: sequencer, slot flags, counters and result register.
// Sequencing: publish and acquire pass from acceptance through a serial scan of the n active
//   slots in the sequence store, one slot a cycle, then the drain and finish states to the result.
// Release, rejected and fatal requests skip the scan and go straight to the finish state.
// One request at a time: a new request is taken only once the last result is registered.
// Reset (async, active low) clears slot flags, counters and fatal state at once;
//   the sequence store needs no clearing since only the sequence numbers of valid slots are used.
module frame_slot_manager_overwrite_oldest_core #(
  parameter int unsigned MAX_SLOTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fsmo_in_if.sink    in_i,
  fsmo_out_if.source out_o,
  fsmo_cfg_if.sink   cfg_i
);

  localparam int unsigned IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state_q, state_d;

  // captured request word
  logic [fsmo_pkg::ACTION_W-1:0] act_q;
  logic [fsmo_pkg::SIZE_W-1:0]   size_q;
  logic [fsmo_pkg::SLOT_W-1:0]   rel_q;

  // configuration
  logic [fsmo_pkg::NSLOT_W-1:0]    cfg_slots_q;
  logic [fsmo_pkg::CFG_DATA_W-1:0] cfg_cap_q;

  // slot state
  logic [MAX_SLOTS-1:0]         valid_q;
  logic [MAX_SLOTS-1:0]         leased_q;
  logic [fsmo_pkg::SEQ_W-1:0]   next_seq_q;
  logic [fsmo_pkg::DROP_W-1:0]  dropped_q, dropped_d;
  logic                         fatal_q;

  // scan pipeline
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             p_vld_q, p_vld_d;
  logic [IDX_W-1:0] p_idx_q;
  logic [CNT_W-1:0] n_act;

  // result register
  logic                          out_vld_q;
  logic [fsmo_pkg::STATUS_W-1:0] out_st_q;
  logic [fsmo_pkg::SLOT_W-1:0]   out_slot_q;
  logic [fsmo_pkg::SEQ_W-1:0]    out_seq_q;
  logic                          out_over_q;
  logic [fsmo_pkg::DROP_W-1:0]   out_drop_q;

  // completion decode
  logic                          in_acc, need_scan, fin_fire;
  logic [fsmo_pkg::STATUS_W-1:0] st_c;
  logic [fsmo_pkg::SLOT_W-1:0]   slot_c;
  logic [fsmo_pkg::SEQ_W-1:0]    seq_c;
  logic                          over_c, drop_inc, set_fatal, pub_wr, acq_grant, rel_clr;
  logic [IDX_W-1:0]              w_idx, b_idx, r_idx;

  fsmo_pkg::scan_ctrl_t       scan_ctrl;
  fsmo_pkg::scan_res_t        scan_res;
  logic [fsmo_pkg::SEQ_W-1:0] ram_rdata;
  logic                       ram_re;

  // active slot count, clamped to 1..MAX_SLOTS
  always_comb begin
    if (cfg_slots_q == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(cfg_slots_q) > 32'(MAX_SLOTS)) begin
      n_act = CNT_W'(MAX_SLOTS);
    end else begin
      n_act = CNT_W'(cfg_slots_q);
    end
  end

  // configuration writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_slots_q <= fsmo_pkg::RST_SLOTS_IN_USE;
      cfg_cap_q   <= fsmo_pkg::RST_SLOT_CAPACITY;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == fsmo_pkg::REG_SLOTS_IN_USE) begin
        cfg_slots_q <= cfg_i.data[fsmo_pkg::NSLOT_W-1:0];
      end else if (cfg_i.index == fsmo_pkg::REG_SLOT_CAPACITY) begin
        cfg_cap_q <= cfg_i.data;
      end
    end
  end

  // request side: one word in flight
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign need_scan  = !fatal_q && ((in_i.action == fsmo_pkg::ACT_ACQUIRE) ||
                      ((in_i.action == fsmo_pkg::ACT_PUBLISH) && (in_i.frame_size != '0)));

  // result register frees up when taken or empty
  assign fin_fire = (state_q == S_FIN) && (!out_vld_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    p_vld_d = 1'b0;
    ram_re  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cnt_d   = '0;
          state_d = need_scan ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        ram_re  = 1'b1;
        p_vld_d = 1'b1;
        if (cnt_q == (n_act - CNT_W'(1))) begin
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_DRAIN: begin
        // last slot is evaluated this cycle
        state_d = S_FIN;
      end
      S_FIN: begin
        if (fin_fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      p_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      p_vld_q <= p_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= in_i.action;
      size_q <= in_i.frame_size;
      rel_q  <= in_i.release_index;
    end
    // index tag is registered alongside the read data
    p_idx_q <= cnt_q[IDX_W-1:0];
  end

  // scan unit sees the slot whose sequence number has just been read
  always_comb begin
    scan_ctrl.clear         = in_acc;
    scan_ctrl.elem_vld      = p_vld_q;
    scan_ctrl.elem_idx      = fsmo_pkg::IDX_MAX_W'(p_idx_q);
    scan_ctrl.elem_free     = !valid_q[p_idx_q] && !leased_q[p_idx_q];
    scan_ctrl.elem_readable = valid_q[p_idx_q] && !leased_q[p_idx_q];
  end

  fsmo_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (scan_ctrl),
    .seq_i  (ram_rdata),
    .res_o  (scan_res)
  );

  assign b_idx = IDX_W'(scan_res.best_idx);
  assign w_idx = scan_res.free_found ? IDX_W'(scan_res.free_idx) : b_idx;
  assign r_idx = IDX_W'(rel_q);

  // outcome of the request once the scan has settled
  always_comb begin
    st_c      = fsmo_pkg::ST_DONE;
    slot_c    = '0;
    seq_c     = '0;
    over_c    = 1'b0;
    drop_inc  = 1'b0;
    set_fatal = 1'b0;
    pub_wr    = 1'b0;
    acq_grant = 1'b0;
    rel_clr   = 1'b0;
    unique case (act_q)
      fsmo_pkg::ACT_PUBLISH: begin
        if (fatal_q) begin
          st_c = fsmo_pkg::ST_FATAL;
        end else if (size_q == '0) begin
          st_c = fsmo_pkg::ST_INVALID;
        end else begin
          // no free slot: either an overwrite or an outright drop, one count each
          drop_inc = !scan_res.free_found;
          if (!scan_res.free_found && !scan_res.best_found) begin
            st_c = fsmo_pkg::ST_DROPPED;
          end else if (size_q > cfg_cap_q) begin
            set_fatal = 1'b1;
            st_c      = fsmo_pkg::ST_FATAL;
          end else begin
            pub_wr = 1'b1;
            slot_c = fsmo_pkg::SLOT_W'(w_idx);
            seq_c  = next_seq_q;
            over_c = !scan_res.free_found;
          end
        end
      end
      fsmo_pkg::ACT_ACQUIRE: begin
        if (fatal_q) begin
          st_c = fsmo_pkg::ST_FATAL;
        end else if (!scan_res.best_found) begin
          st_c = fsmo_pkg::ST_EMPTY;
        end else begin
          acq_grant = 1'b1;
          slot_c    = fsmo_pkg::SLOT_W'(b_idx);
          seq_c     = scan_res.oldest_seq;
        end
      end
      fsmo_pkg::ACT_RELEASE: begin
        if (32'(rel_q) >= 32'(n_act)) begin
          st_c = fsmo_pkg::ST_INVALID;
        end else begin
          rel_clr = 1'b1;
        end
      end
      default: st_c = fsmo_pkg::ST_INVALID;
    endcase
  end

  // saturating drop counter
  always_comb begin
    dropped_d = dropped_q;
    if (drop_inc && (dropped_q != '1)) begin
      dropped_d = dropped_q + fsmo_pkg::DROP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      leased_q   <= '0;
      next_seq_q <= fsmo_pkg::SEQ_W'(1);
      dropped_q  <= '0;
      fatal_q    <= 1'b0;
    end else if (fin_fire) begin
      dropped_q <= dropped_d;
      if (set_fatal) begin
        fatal_q <= 1'b1;
      end
      if (pub_wr) begin
        valid_q[w_idx] <= 1'b1;
        next_seq_q     <= next_seq_q + fsmo_pkg::SEQ_W'(1);
      end
      if (acq_grant) begin
        valid_q[b_idx]  <= 1'b0;
        leased_q[b_idx] <= 1'b1;
      end
      if (rel_clr) begin
        leased_q[r_idx] <= 1'b0;
      end
    end
  end

  fsmo_seq_ram #(
    .DEPTH (MAX_SLOTS),
    .AW    (IDX_W)
  ) u_seq_ram (
    .clk_i   (clk_i),
    .we_i    (fin_fire && pub_wr),
    .waddr_i (w_idx),
    .wdata_i (next_seq_q),
    .re_i    (ram_re),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fin_fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      out_st_q   <= st_c;
      out_slot_q <= slot_c;
      out_seq_q  <= seq_c;
      out_over_q <= over_c;
      out_drop_q <= dropped_d;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.status         = out_st_q;
  assign out_o.slot_number    = out_slot_q;
  assign out_o.frame_sequence = out_seq_q;
  assign out_o.overwrote_old  = out_over_q;
  assign out_o.drop_count     = out_drop_q;

  // a slot never holds an unread frame while leased
  a_valid_leased_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q & leased_q) == '0)
    else $error("slot both valid and leased");

  // store write and scan read never share a cycle
  a_ram_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_re && fin_fire && pub_wr))
    else $error("sequence store read and write collide");

  // drop count only grows
  a_drop_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (dropped_q >= $past(dropped_q)))
    else $error("drop count went backwards");

  // fatal state is sticky
  a_fatal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fatal_q |=> fatal_q)
    else $error("fatal state cleared");

  // a scan word is only in the pipe during scan or drain
  a_pipe_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld_q |-> ((state_q == S_SCAN) || (state_q == S_DRAIN)))
    else $error("scan word outside scan");

endmodule

// ----- bench/tb_frame_slot_manager_overwrite_oldest_core.sv -----
// Self-checking bench for the frame slot manager: directed and random requests.
module tb_frame_slot_manager_overwrite_oldest_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MODEL_SLOTS   = 16;
  localparam int          CLK_PERIOD    = 10;
  localparam int          IDLE_PCT      = 24;
  // a scan over 16 slots plus result register, with margin
  localparam int          SETTLE_CYCLES = 30;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          PHASE_WORDS   = 175;
  // the one action code that the block does not know
  localparam logic [fsmo_pkg::ACTION_W-1:0] ACT_UNDEFINED = 2'd3;

  typedef struct packed {
    logic [fsmo_pkg::STATUS_W-1:0] status;
    logic [fsmo_pkg::SLOT_W-1:0]   slot;
    logic [fsmo_pkg::SEQ_W-1:0]    seq;
    logic                          overwrote;
    logic [fsmo_pkg::DROP_W-1:0]   drops;
  } slot_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  fsmo_in_if  in_if ();
  fsmo_out_if out_if ();
  fsmo_cfg_if cfg_if ();

  frame_slot_manager_overwrite_oldest_core #(
    .MAX_SLOTS(MODEL_SLOTS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Slot bookkeeping mirror: what the block should hold after every accepted
  // request word. Updated at the edge where the request handshake completes.
  // ---------------------------------------------------------------------------
  logic                         unread_m [MODEL_SLOTS];
  logic                         leased_m [MODEL_SLOTS];
  logic [fsmo_pkg::SEQ_W-1:0]   stamp_m  [MODEL_SLOTS];
  logic [fsmo_pkg::SEQ_W-1:0]   seq_next_m;
  logic [fsmo_pkg::DROP_W-1:0]  drops_m;
  logic                         fatal_m;
  logic [fsmo_pkg::NSLOT_W-1:0] slots_cfg;
  logic [fsmo_pkg::SIZE_W-1:0]  capacity_m;

  slot_result_t results_due [$];
  int           error_count;

  // idling knobs and the long receiver hold-off request
  int           req_idle_pct;
  int           rsp_idle_pct;
  int unsigned  hold_req_cnt;
  int unsigned  hold_ack_cnt;
  int unsigned  hold_left;

  // 0 behaves as 1, anything above the build size as the build size
  function automatic int active_slots();
    int n;
    n = slots_cfg;
    if (n < 1) n = 1;
    if (n > MODEL_SLOTS) n = MODEL_SLOTS;
    return n;
  endfunction

  // oldest unread, unleased slot among the active ones, -1 if none
  function automatic int oldest_unread();
    int best;
    int n;
    best = -1;
    n    = active_slots();
    for (int i = 0; i < n; i++) begin
      if (unread_m[i] && !leased_m[i]) begin
        if (best < 0 || stamp_m[i] < stamp_m[best]) best = i;
      end
    end
    return best;
  endfunction

  function automatic void bump_drops();
    if (drops_m != '1) drops_m++;
  endfunction

  // Work out the answer to one accepted request and queue it.
  function automatic void apply_request(input logic [fsmo_pkg::ACTION_W-1:0] act,
                                        input logic [fsmo_pkg::SIZE_W-1:0]   size,
                                        input logic [fsmo_pkg::SLOT_W-1:0]   rel);
    slot_result_t r;
    int           n;
    int           w;
    bit           replaced;
    r        = '0;
    r.status = fsmo_pkg::ST_DONE;
    n        = active_slots();
    case (act)
      fsmo_pkg::ACT_PUBLISH: begin
        if (fatal_m) begin
          r.status = fsmo_pkg::ST_FATAL;
        end else if (size == '0) begin
          r.status = fsmo_pkg::ST_INVALID;
        end else begin
          w        = -1;
          replaced = 1'b0;
          for (int i = 0; i < n; i++) begin
            if (!unread_m[i] && !leased_m[i]) begin
              w = i;
              break;
            end
          end
          if (w < 0) begin
            w = oldest_unread();
            if (w >= 0) begin
              replaced = 1'b1;
              bump_drops();
            end
          end
          if (w < 0) begin
            bump_drops();
            r.status = fsmo_pkg::ST_DROPPED;
          end else if (size > capacity_m) begin
            // the overwrite drop above still stands, the slot is untouched
            fatal_m  = 1'b1;
            r.status = fsmo_pkg::ST_FATAL;
          end else begin
            stamp_m[w]  = seq_next_m;
            seq_next_m  = seq_next_m + 1'b1;
            unread_m[w] = 1'b1;
            r.slot      = w[fsmo_pkg::SLOT_W-1:0];
            r.seq       = stamp_m[w];
            r.overwrote = replaced;
          end
        end
      end
      fsmo_pkg::ACT_ACQUIRE: begin
        if (fatal_m) begin
          r.status = fsmo_pkg::ST_FATAL;
        end else begin
          w = oldest_unread();
          if (w < 0) begin
            r.status = fsmo_pkg::ST_EMPTY;
          end else begin
            leased_m[w] = 1'b1;
            unread_m[w] = 1'b0;
            r.slot      = w[fsmo_pkg::SLOT_W-1:0];
            r.seq       = stamp_m[w];
          end
        end
      end
      fsmo_pkg::ACT_RELEASE: begin
        // release still works in the fatal state
        if (rel >= n) r.status = fsmo_pkg::ST_INVALID;
        else          leased_m[rel] = 1'b0;
      end
      default: r.status = fsmo_pkg::ST_INVALID;
    endcase
    r.drops = drops_m;
    results_due.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Valid is only lowered by a gap or by settle(), so a word
  // offered back to back never sees valid dropped and raised in one step.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [fsmo_pkg::ACTION_W-1:0] act,
                              input logic [fsmo_pkg::SIZE_W-1:0]   size,
                              input logic [fsmo_pkg::SLOT_W-1:0]   rel);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.action        <= act;
    in_if.frame_size    <= size;
    in_if.release_index <= rel;
    do @(posedge clk_i); while (!in_if.ready);
    apply_request(act, size, rel);
  endtask

  // Stop offering, wait for every queued answer, then let the block go quiet.
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [fsmo_pkg::CFG_IDX_W-1:0]  idx,
                                input logic [fsmo_pkg::CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == fsmo_pkg::REG_SLOTS_IN_USE)       slots_cfg  = value[fsmo_pkg::NSLOT_W-1:0];
    else if (idx == fsmo_pkg::REG_SLOT_CAPACITY) capacity_m = value;
    @(posedge clk_i);
  endtask

  // registers only change with the block idle
  task automatic configure(input logic [fsmo_pkg::NSLOT_W-1:0] slots,
                           input logic [fsmo_pkg::SIZE_W-1:0]  cap);
    settle();
    write_register(fsmo_pkg::REG_SLOTS_IN_USE, fsmo_pkg::CFG_DATA_W'(slots));
    write_register(fsmo_pkg::REG_SLOT_CAPACITY, cap);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random ready, plus a long counted hold-off on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt <= hold_req_cnt;
      hold_left    <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // every result word is held against the oldest answer still owed
  always @(posedge clk_i) begin
    slot_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got status %0d", $time,
                 out_if.status);
        error_count++;
      end else begin
        want = results_due.pop_front();
        check_field("status", 64'(want.status), 64'(out_if.status));
        check_field("slot_number", 64'(want.slot), 64'(out_if.slot_number));
        check_field("frame_sequence", want.seq, out_if.frame_sequence);
        check_field("overwrote_old", 64'(want.overwrote), 64'(out_if.overwrote_old));
        check_field("drop_count", 64'(want.drops), 64'(out_if.drop_count));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // empty acquire, plain publishes, harmless release, rejects
  task automatic test_publish_acquire_basic();
    send_request(fsmo_pkg::ACT_ACQUIRE, '0, '0);
    send_request(fsmo_pkg::ACT_PUBLISH, 16'd1, '0);
    send_request(fsmo_pkg::ACT_PUBLISH, 16'd4096, '0);
    send_request(fsmo_pkg::ACT_RELEASE, '0, 4'd0);  // slot not leased: done, no change
    send_request(fsmo_pkg::ACT_ACQUIRE, '0, '0);
    send_request(fsmo_pkg::ACT_RELEASE, '0, 4'd0);
    send_request(fsmo_pkg::ACT_PUBLISH, 16'd0, '0); // zero size
    send_request(ACT_UNDEFINED, 16'hFFFF, 4'hF);
    send_request(fsmo_pkg::ACT_RELEASE, '0, 4'd15);
  endtask

  // two slots: overwrite of the oldest, then drops once every slot is leased
  task automatic test_overwrite_oldest();
    configure(5'd2, 16'd4096);
    send_request(fsmo_pkg::ACT_PUBLISH, 16'd7, '0);
    send_request(fsmo_pkg::ACT_PUBLISH, 16'd8, '0);
    send_request(fsmo_pkg::ACT_ACQUIRE, '0, '0);
    send_request(fsmo_pkg::ACT_PUBLISH, 16'd9, '0);
    send_request(fsmo_pkg::ACT_ACQUIRE, '0, '0);
    send_request(fsmo_pkg::ACT_PUBLISH, 16'd10, '0);    // no slot at all
    send_request(fsmo_pkg::ACT_PUBLISH, 16'hFFFF, '0);  // oversize, nowhere to go: drop
    send_request(fsmo_pkg::ACT_RELEASE, '0, 4'd2);      // beyond the active count
    send_request(fsmo_pkg::ACT_RELEASE, '0, 4'd1);
  endtask

  // active count of 0 acts as 1, 31 acts as the full build
  task automatic test_slot_count_limits();
    configure(5'd0, 16'd4096);
    send_request(fsmo_pkg::ACT_PUBLISH, 16'd10, '0);
    send_request(fsmo_pkg::ACT_RELEASE, '0, 4'd1);
    send_request(fsmo_pkg::ACT_RELEASE, '0, 4'd0);
    send_request(fsmo_pkg::ACT_PUBLISH, 16'd4096, '0);
    configure(5'd31, 16'd4096);
    send_request(fsmo_pkg::ACT_RELEASE, '0, 4'd15);
    send_request(fsmo_pkg::ACT_ACQUIRE, '0, '0);
  endtask

  // Mostly well-formed traffic over several settings; oversize frames only
  // where no slot is writable, so the fatal state is kept for the last test.
  task automatic test_random_traffic();
    logic [fsmo_pkg::NSLOT_W-1:0] slot_set [8] = '{5'd16, 5'd1, 5'd0, 5'd31,
                                                   5'd5, 5'd3, 5'd16, 5'd9};
    logic [fsmo_pkg::SIZE_W-1:0]  cap_set  [8] = '{16'd4096, 16'hFFFF, 16'd100, 16'd1,
                                                   16'd0, 16'd2000, 16'hFFFF, 16'd300};
    logic [fsmo_pkg::SIZE_W-1:0]  cap;
    logic [fsmo_pkg::SIZE_W-1:0]  size;
    int                           pick;
    int                           n;
    int                           held_q [$];
    for (int ph = 0; ph < 8; ph++) begin
      cap = (ph == 4) ? fsmo_pkg::SIZE_W'($urandom_range(1, 65535)) : cap_set[ph];
      configure(slot_set[ph], cap);
      // one phase runs flat out on both sides
      req_idle_pct = (ph == 6) ? 0 : IDLE_PCT;
      rsp_idle_pct = (ph == 6) ? 0 : IDLE_PCT;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        n = active_slots();
        held_q.delete();
        for (int i = 0; i < n; i++) if (leased_m[i]) held_q.push_back(i);
        pick = $urandom_range(0, 99);
        if (pick < 10)      size = 16'd1;
        else if (pick < 20) size = capacity_m;
        else                size = fsmo_pkg::SIZE_W'($urandom_range(1, capacity_m));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          send_request(fsmo_pkg::ACT_PUBLISH, size, fsmo_pkg::SLOT_W'($urandom));
        end else if (pick < 70) begin
          send_request(fsmo_pkg::ACT_ACQUIRE, fsmo_pkg::SIZE_W'($urandom),
                       fsmo_pkg::SLOT_W'($urandom));
        end else if (pick < 88) begin
          if (held_q.size() != 0)
            send_request(fsmo_pkg::ACT_RELEASE, fsmo_pkg::SIZE_W'($urandom),
                         fsmo_pkg::SLOT_W'(held_q[$urandom_range(0, held_q.size() - 1)]));
          else
            send_request(fsmo_pkg::ACT_RELEASE, fsmo_pkg::SIZE_W'($urandom),
                         fsmo_pkg::SLOT_W'($urandom));
        end else begin
          case ($urandom_range(0, 3))
            0: send_request(fsmo_pkg::ACT_PUBLISH, '0, fsmo_pkg::SLOT_W'($urandom));
            1: send_request(ACT_UNDEFINED, fsmo_pkg::SIZE_W'($urandom),
                            fsmo_pkg::SLOT_W'($urandom));
            2: send_request(fsmo_pkg::ACT_RELEASE, fsmo_pkg::SIZE_W'($urandom),
                            fsmo_pkg::SLOT_W'($urandom));
            default: begin
              if (held_q.size() == n && capacity_m != '1)
                send_request(fsmo_pkg::ACT_PUBLISH,
                             fsmo_pkg::SIZE_W'($urandom_range(capacity_m + 1, 65535)),
                             fsmo_pkg::SLOT_W'($urandom));
              else
                send_request(fsmo_pkg::ACT_PUBLISH, size, fsmo_pkg::SLOT_W'($urandom));
            end
          endcase
        end
      end
    end
    req_idle_pct = IDLE_PCT;
    rsp_idle_pct = IDLE_PCT;
  endtask

  // result side holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    configure(5'd4, 16'd512);
    req_idle_pct = 0;
    hold_req_cnt <= hold_req_cnt + 1;
    for (int k = 0; k < 30; k++) begin
      if (k % 3 == 2) send_request(fsmo_pkg::ACT_ACQUIRE, '0, '0);
      else            send_request(fsmo_pkg::ACT_PUBLISH,
                                   fsmo_pkg::SIZE_W'($urandom_range(1, 512)), '0);
    end
    req_idle_pct = IDLE_PCT;
  endtask

  // Sticky fatal state: an overwrite with a frame too large for the slot.
  // Runs last, since only reset clears it.
  task automatic test_fatal_oversize();
    configure(5'd2, 16'd100);
    send_request(fsmo_pkg::ACT_RELEASE, '0, 4'd0);
    send_request(fsmo_pkg::ACT_RELEASE, '0, 4'd1);
    send_request(fsmo_pkg::ACT_PUBLISH, 16'd100, '0);   // exactly the capacity
    send_request(fsmo_pkg::ACT_PUBLISH, 16'd100, '0);
    // both slots now unread, none free: next publish must overwrite
    configure(5'd2, 16'd0);
    send_request(fsmo_pkg::ACT_PUBLISH, 16'd1, '0);
    send_request(fsmo_pkg::ACT_PUBLISH, 16'd1, '0);
    send_request(fsmo_pkg::ACT_ACQUIRE, '0, '0);
    send_request(fsmo_pkg::ACT_RELEASE, '0, 4'd0);
    send_request(fsmo_pkg::ACT_RELEASE, '0, 4'd5);
    send_request(ACT_UNDEFINED, '0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < MODEL_SLOTS; i++) begin
      unread_m[i] = 1'b0;
      leased_m[i] = 1'b0;
      stamp_m[i]  = '0;
    end
    seq_next_m   = 64'd1;
    drops_m      = '0;
    fatal_m      = 1'b0;
    slots_cfg    = fsmo_pkg::RST_SLOTS_IN_USE;
    capacity_m   = fsmo_pkg::RST_SLOT_CAPACITY;
    error_count  = 0;
    req_idle_pct = IDLE_PCT;
    rsp_idle_pct = IDLE_PCT;
    hold_req_cnt = 0;
    hold_ack_cnt = 0;
    hold_left    = 0;

    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.action         = fsmo_pkg::ACT_PUBLISH;
    in_if.frame_size     = '0;
    in_if.release_index  = '0;
    out_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = fsmo_pkg::REG_SLOTS_IN_USE;
    cfg_if.data          = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_publish_acquire_basic();
    test_overwrite_oldest();
    test_slot_count_limits();
    test_random_traffic();
    test_backpressure();
    test_fatal_oversize();

    settle();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
